FILE: src/mqrm_pkg.sv
// Package for the multi-queue ring manager: command and status codes,
// register indices. No dependencies.
package mqrm_pkg;

  localparam logic [3:0] CMD_ADD       = 4'd0;
  localparam logic [3:0] CMD_FETCH     = 4'd1;
  localparam logic [3:0] CMD_PEEK      = 4'd2;
  localparam logic [3:0] CMD_FLUSH     = 4'd3;
  localparam logic [3:0] CMD_FLUSH_ALL = 4'd4;
  localparam logic [3:0] CMD_CLR       = 4'd5;
  localparam logic [3:0] CMD_CLR_ALL   = 4'd6;
  localparam logic [3:0] CMD_OVF       = 4'd7;
  localparam logic [3:0] CMD_QUERY     = 4'd8;
  localparam logic [3:0] CMD_REPLACE   = 4'd9;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic [0:0] REG_CAP   = 1'b0;
  localparam logic [0:0] REG_COUNT = 1'b1;

endpackage

FILE: src/mqrm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module mqrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: src/multi_queue_ring_manager.sv
// Top level of the multi-queue ring manager: command decode, per-queue
// state read-modify-write and result register. Uses mqrm_pkg and mqrm_ram.
//
//   channel | signals                                        | role
//   input   | in_valid/in_ready cmd queue_sel item slot       | commands
//   output  | out_valid/out_ready status item_out ... counts  | one result each
//   config  | psel penable pwrite paddr pwdata prdata pready  | registers
//
// A command passes through accept, state/item memory read, write back,
// state re-read and result register. Flush all and clear all instead read
// and write back each queue in use in turn before the state re-read.
// After reset and after every register write the state memory is cleared,
// one queue per cycle, while no command is accepted.
// A result waiting at the output does not block the next command; a second
// result waits in the last state until the first one is taken.
module multi_queue_ring_manager #(
  parameter int MAX_QUEUES    = 16,
  parameter int QUEUE_DEPTH   = 256,
  parameter int ITEM_WIDTH    = 32,
  parameter int COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  cmd,
  input  logic [7:0]  queue_sel,
  input  logic [31:0] item,
  input  logic [11:0] slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] item_out,
  output logic [11:0] slot_out,
  output logic [8:0]  fill_level,
  output logic        is_full,
  output logic [31:0] insert_count,
  output logic [31:0] fetch_count,
  output logic [31:0] peek_count,
  output logic [31:0] flush_count,
  output logic [31:0] empty_count,
  output logic [31:0] overflow_count
);
  localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = MAX_QUEUES * QUEUE_DEPTH;
  localparam int SW = $clog2(SLOTS);
  localparam int CW = COUNTER_WIDTH;
  localparam int QSW = 2 * PW + OW + 6 * CW;
  localparam int CNTW = $clog2(MAX_QUEUES + 1);

  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic [OW-1:0] occ;
    logic [CW-1:0] c_ins;
    logic [CW-1:0] c_fetch;
    logic [CW-1:0] c_peek;
    logic [CW-1:0] c_flush;
    logic [CW-1:0] c_empty;
    logic [CW-1:0] c_ovf;
  } qstate_t;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_WALKW = 3'd5;
  localparam logic [2:0] S_SNAP = 3'd6;
  localparam logic [2:0] S_OUT = 3'd7;

  logic [2:0] state;
  logic [8:0] cap_reg;
  logic [4:0] count_reg;
  logic [QW-1:0] walk;
  logic [3:0] c_cmd;
  logic [7:0] c_qid;
  logic [ITEM_WIDTH-1:0] c_item;
  logic [11:0] c_slot;

  // effective capacity and queue count
  logic [OW-1:0] cap;
  logic [CNTW-1:0] nq;
  always_comb begin
    if (cap_reg == 9'd0) cap = OW'(1);
    else if (32'(cap_reg) > QUEUE_DEPTH) cap = OW'(QUEUE_DEPTH);
    else cap = OW'(cap_reg);
    if (32'(count_reg) > MAX_QUEUES) nq = CNTW'(MAX_QUEUES);
    else nq = CNTW'(count_reg);
  end
  logic c_valid;
  assign c_valid = 32'(c_qid) < 32'(nq);

  // queue state memory
  logic q_we;
  logic [QW-1:0] q_waddr, q_raddr;
  qstate_t q_wdata, q_rdata;
  logic [QSW-1:0] q_rbits;
  assign q_rdata = qstate_t'(q_rbits);
  mqrm_ram #(.WIDTH(QSW), .DEPTH(MAX_QUEUES)) u_qram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(QSW'(q_wdata)),
    .raddr(q_raddr), .rdata(q_rbits));

  // item memory
  logic i_we;
  logic [SW-1:0] i_waddr, i_raddr;
  logic [ITEM_WIDTH-1:0] i_wdata, i_rdata;
  mqrm_ram #(.WIDTH(ITEM_WIDTH), .DEPTH(SLOTS)) u_iram (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .raddr(i_raddr), .rdata(i_rdata));

  // slot base: qid*cap, registered at accept
  logic [SW-1:0] base;
  logic [SW-1:0] hslot, tslot;
  assign hslot = base + SW'(q_rdata.head);
  assign tslot = base + SW'(q_rdata.tail);

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      mqrm_pkg::REG_CAP:   prdata = 32'(cap_reg);
      mqrm_pkg::REG_COUNT: prdata = 32'(count_reg);
      default:   prdata = '0;
    endcase
  end

  // execute: modify fetched queue record
  qstate_t nx;
  logic [1:0] ex_status;
  logic ex_slot_ok, ex_item_ok;
  logic [PW-1:0] tail_inc, head_inc;
  always_comb begin
    nx = q_rdata;
    ex_status = mqrm_pkg::ST_OK;
    ex_slot_ok = 1'b0;
    ex_item_ok = 1'b0;
    tail_inc = (OW'(q_rdata.tail) + OW'(1) >= cap) ? '0 : q_rdata.tail + PW'(1);
    head_inc = (OW'(q_rdata.head) + OW'(1) >= cap) ? '0 : q_rdata.head + PW'(1);
    case (c_cmd)
      mqrm_pkg::CMD_ADD: begin
        if (q_rdata.occ >= cap) begin
          nx.c_ovf = q_rdata.c_ovf + CW'(1);
          ex_status = mqrm_pkg::ST_FULL;
        end else begin
          nx.occ = q_rdata.occ + OW'(1);
          nx.c_ins = q_rdata.c_ins + CW'(1);
          nx.tail = tail_inc;
          ex_slot_ok = 1'b1;
        end
      end
      mqrm_pkg::CMD_FETCH, mqrm_pkg::CMD_PEEK: begin
        if (q_rdata.occ == '0) begin
          nx.c_empty = q_rdata.c_empty + CW'(1);
          ex_status = mqrm_pkg::ST_EMPTY;
        end else begin
          ex_item_ok = 1'b1;
          if (c_cmd == mqrm_pkg::CMD_PEEK) begin
            nx.c_peek = q_rdata.c_peek + CW'(1);
          end else begin
            nx.occ = q_rdata.occ - OW'(1);
            nx.c_fetch = q_rdata.c_fetch + CW'(1);
            nx.head = head_inc;
          end
        end
      end
      mqrm_pkg::CMD_FLUSH, mqrm_pkg::CMD_FLUSH_ALL: begin
        nx.head = '0;
        nx.tail = '0;
        nx.occ = '0;
        nx.c_flush = q_rdata.c_flush + CW'(1);
      end
      mqrm_pkg::CMD_CLR, mqrm_pkg::CMD_CLR_ALL: begin
        nx.c_ins = '0; nx.c_fetch = '0; nx.c_peek = '0;
        nx.c_flush = '0; nx.c_empty = '0; nx.c_ovf = '0;
      end
      mqrm_pkg::CMD_OVF: nx.c_ovf = q_rdata.c_ovf + CW'(1);
      default: ;
    endcase
  end

  logic is_walk_cmd;
  assign is_walk_cmd = (c_cmd == mqrm_pkg::CMD_FLUSH_ALL) || (c_cmd == mqrm_pkg::CMD_CLR_ALL);
  logic mod_cmd;
  assign mod_cmd = (c_cmd <= mqrm_pkg::CMD_OVF) && !is_walk_cmd;

  logic [QW-1:0] c_q;
  assign c_q = c_qid[QW-1:0];

  // memory port control
  always_comb begin
    q_we = 1'b0;
    q_waddr = walk;
    q_wdata = '0;
    q_raddr = c_q;
    i_we = 1'b0;
    i_waddr = tslot;
    i_wdata = c_item;
    i_raddr = hslot;
    unique case (state)
      S_INIT: q_we = 1'b1;
      S_IDLE: q_raddr = queue_sel[QW-1:0];
      S_EXEC: begin
        q_waddr = c_q;
        q_wdata = nx;
        q_we = c_valid && mod_cmd;
        i_we = c_valid && (c_cmd == mqrm_pkg::CMD_ADD) && ex_slot_ok;
        if (c_cmd == mqrm_pkg::CMD_REPLACE) begin
          i_waddr = c_slot[SW-1:0];
          i_we = (32'(c_slot) < SLOTS);
        end
      end
      S_WALK: q_raddr = walk;
      S_WALKW: begin
        q_wdata = nx;
        q_we = 1'b1;
      end
      default: ;
    endcase
  end

  logic [1:0] r_status;
  logic [11:0] r_slot;
  logic r_item_ok;
  logic r_read_item;
  logic [ITEM_WIDTH-1:0] i_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      walk <= '0;
      cap_reg <= 9'd256;
      count_reg <= 5'd16;
      out_valid <= 1'b0;
      r_read_item <= 1'b0;
    end else begin
      r_read_item <= 1'b0;
      // a result loaded in S_OUT sets out_valid itself
      if (out_valid && out_ready && (state != S_OUT || cfg_wr)) out_valid <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2] == mqrm_pkg::REG_CAP) cap_reg <= pwdata[8:0];
        else count_reg <= pwdata[4:0];
        state <= S_INIT;
        walk <= '0;
      end else begin
        unique case (state)
          S_INIT: begin
            walk <= walk + QW'(1);
            if (32'(walk) == MAX_QUEUES - 1) state <= S_IDLE;
          end
          S_IDLE: if (in_valid && in_ready) begin
            c_cmd <= cmd;
            c_qid <= queue_sel;
            c_item <= ITEM_WIDTH'(item);
            c_slot <= slot;
            base <= SW'(queue_sel[QW-1:0]) * SW'(cap);
            walk <= '0;
            state <= S_READ;
          end
          S_READ: begin
            if (is_walk_cmd) begin
              r_status <= c_valid ? mqrm_pkg::ST_OK : mqrm_pkg::ST_INVALID;
              r_slot <= '0;
              r_item_ok <= 1'b0;
              state <= (nq == '0) ? S_SNAP : S_WALK;
            end else state <= S_EXEC;
          end
          S_EXEC: begin
            r_status <= c_valid ? ex_status : mqrm_pkg::ST_INVALID;
            r_slot <= (c_valid && c_cmd == mqrm_pkg::CMD_ADD && ex_slot_ok)
                      ? 12'(tslot) : 12'd0;
            r_item_ok <= c_valid && (c_cmd == mqrm_pkg::CMD_FETCH ||
                         c_cmd == mqrm_pkg::CMD_PEEK) && ex_item_ok;
            r_read_item <= 1'b1;
            state <= S_SNAP;
            walk <= c_q;
          end
          S_WALK: state <= S_WALKW;
          S_WALKW: begin
            if (32'(walk) + 1 >= 32'(nq)) begin
              r_status <= c_valid ? mqrm_pkg::ST_OK : mqrm_pkg::ST_INVALID;
              r_slot <= '0;
              r_item_ok <= 1'b0;
              state <= S_SNAP;
            end else begin
              walk <= walk + QW'(1);
              state <= S_WALK;
            end
          end
          S_SNAP: state <= S_OUT; // re-read addressed queue after write
          S_OUT: if (!out_valid || out_ready) begin
            state <= S_IDLE;
            out_valid <= 1'b1;
            status <= r_status;
            item_out <= r_item_ok ? 32'(i_hold) : 32'd0;
            slot_out <= r_slot;
            if (c_valid) begin
              fill_level <= 9'(q_rdata.occ);
              is_full <= q_rdata.occ >= cap;
              insert_count <= 32'(q_rdata.c_ins);
              fetch_count <= 32'(q_rdata.c_fetch);
              peek_count <= 32'(q_rdata.c_peek);
              flush_count <= 32'(q_rdata.c_flush);
              empty_count <= 32'(q_rdata.c_empty);
              overflow_count <= 32'(q_rdata.c_ovf);
            end else begin
              fill_level <= '0; is_full <= 1'b1;
              insert_count <= '0; fetch_count <= '0; peek_count <= '0;
              flush_count <= '0; empty_count <= '0; overflow_count <= '0;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // hold item read data captured right after execute
  always_ff @(posedge clk) begin
    if (r_read_item) i_hold <= i_rdata;
  end

  assign in_ready = (state == S_IDLE) && !cfg_wr;
endmodule

FILE: verif/tb.sv
// Testbench for multi_queue_ring_manager: drives queue commands, predicts each result
// from a behavioral copy of the ring state and compares every output field.
// Depends on mqrm_pkg and the multi_queue_ring_manager RTL.
module tb;

  localparam int NQ = 16;
  localparam int DEPTH = 256;
  localparam int SLOTS = NQ * DEPTH;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [7:0]  qid;
    logic [31:0] item;
    logic [11:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] item_out;
    logic [11:0] slot_out;
    logic [8:0]  fill;
    logic        full;
    logic [31:0] c_ins, c_fetch, c_peek, c_flush, c_empty, c_ovf;
  } res_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic [3:0] cmd = 0;
  logic [7:0] queue_sel = 0;
  logic [31:0] item = 0;
  logic [11:0] slot = 0;
  logic out_valid, out_ready = 0;
  logic [1:0] status;
  logic [31:0] item_out;
  logic [11:0] slot_out;
  logic [8:0] fill_level;
  logic is_full;
  logic [31:0] insert_count, fetch_count, peek_count, flush_count, empty_count,
               overflow_count;

  multi_queue_ring_manager u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [31:0] ring_mem [SLOTS];
  bit          slot_written [SLOTS];
  int unsigned head_q [NQ], tail_q [NQ], occ_q [NQ];
  logic [31:0] ctr [NQ][6];
  int unsigned cap_reg = 256, count_reg = 16;

  cmd_t pending_cmds [$];
  res_t expected_results [$];
  int errors = 0, cycles = 0, n_results = 0;
  bit quiet = 0;       // no idling at the end
  bit hold_off = 0;    // long receiver stall

  function automatic int unsigned eff_cap();
    return cap_reg < 1 ? 1 : (cap_reg > DEPTH ? DEPTH : cap_reg);
  endfunction

  function automatic int unsigned eff_count();
    return count_reg > NQ ? NQ : count_reg;
  endfunction

  function automatic void reset_queues();
    for (int q = 0; q < NQ; q++) begin
      head_q[q] = 0; tail_q[q] = 0; occ_q[q] = 0;
      for (int e = 0; e < 6; e++) ctr[q][e] = 0;
    end
  endfunction

  function automatic void flush_q(int q);
    head_q[q] = 0; tail_q[q] = 0; occ_q[q] = 0;
    ctr[q][3]++;
  endfunction

  function automatic res_t predict_ring(cmd_t c);
    res_t r;
    int unsigned capv, nv, q, at;
    bit ok;
    capv = eff_cap();
    nv = eff_count();
    q = c.qid;
    ok = q < nv;
    r = '0;
    if (c.cmd == mqrm_pkg::CMD_FLUSH_ALL) begin
      for (int i = 0; i < nv; i++) flush_q(i);
    end else if (c.cmd == mqrm_pkg::CMD_CLR_ALL) begin
      for (int i = 0; i < nv; i++) for (int e = 0; e < 6; e++) ctr[i][e] = 0;
    end else if (c.cmd == mqrm_pkg::CMD_REPLACE) begin
      if (c.slot < SLOTS) begin
        ring_mem[c.slot] = c.item; slot_written[c.slot] = 1;
      end
    end else if (ok && c.cmd <= mqrm_pkg::CMD_QUERY) begin
      case (c.cmd)
        mqrm_pkg::CMD_ADD: begin
          if (occ_q[q] >= capv) begin
            ctr[q][5]++; r.status = mqrm_pkg::ST_FULL;
          end else begin
            at = q * capv + tail_q[q];
            ring_mem[at] = c.item; slot_written[at] = 1;
            r.slot_out = 12'(at);
            occ_q[q]++; ctr[q][0]++;
            tail_q[q] = (tail_q[q] + 1 >= capv) ? 0 : tail_q[q] + 1;
          end
        end
        mqrm_pkg::CMD_FETCH, mqrm_pkg::CMD_PEEK: begin
          if (occ_q[q] == 0) begin
            ctr[q][4]++; r.status = mqrm_pkg::ST_EMPTY;
          end else begin
            r.item_out = ring_mem[q * capv + head_q[q]];
            if (c.cmd == mqrm_pkg::CMD_PEEK) ctr[q][2]++;
            else begin
              occ_q[q]--; ctr[q][1]++;
              head_q[q] = (head_q[q] + 1 >= capv) ? 0 : head_q[q] + 1;
            end
          end
        end
        mqrm_pkg::CMD_FLUSH: flush_q(q);
        mqrm_pkg::CMD_CLR: for (int e = 0; e < 6; e++) ctr[q][e] = 0;
        mqrm_pkg::CMD_OVF: ctr[q][5]++;
        default: ;
      endcase
    end
    if (!ok) begin
      r = '0; r.status = mqrm_pkg::ST_INVALID; r.full = 1;
      return r;
    end
    r.fill = 9'(occ_q[q]);
    r.full = occ_q[q] >= capv;
    r.c_ins = ctr[q][0]; r.c_fetch = ctr[q][1]; r.c_peek = ctr[q][2];
    r.c_flush = ctr[q][3]; r.c_empty = ctr[q][4]; r.c_ovf = ctr[q][5];
    return r;
  endfunction

  // keep fetch/peek off never-written slots: turn such a read into a query
  function automatic cmd_t sanitize(cmd_t c);
    int unsigned q;
    q = c.qid;
    if ((c.cmd == mqrm_pkg::CMD_FETCH || c.cmd == mqrm_pkg::CMD_PEEK) &&
        q < eff_count() && occ_q[q] != 0 &&
        !slot_written[q * eff_cap() + head_q[q]])
      c.cmd = mqrm_pkg::CMD_QUERY;
    return c;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_ring(
          cmd_t'{cmd, queue_sel, item, slot}));
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 0;
        end else if (pending_cmds.size() > 0 && !psel) begin
          cmd_t c;
          // predictor state already covers every accepted transaction here
          c = sanitize(pending_cmds.pop_front());
          cmd <= c.cmd; queue_sel <= c.qid; item <= c.item; slot <= c.slot;
          in_valid <= 1;
          if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 14);
        end else in_valid <= 0;
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        res_t e;
        n_results <= n_results + 1;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          errors = errors + 1;
        end else begin
          e = expected_results.pop_front();
          if (status !== e.status) begin
            $error("status exp %0d got %0d", e.status, status); errors = errors + 1; end
          if (item_out !== e.item_out) begin
            $error("item_out exp %h got %h", e.item_out, item_out); errors = errors + 1; end
          if (slot_out !== e.slot_out) begin
            $error("slot_out exp %0d got %0d", e.slot_out, slot_out); errors = errors + 1; end
          if (fill_level !== e.fill) begin
            $error("fill_level exp %0d got %0d", e.fill, fill_level); errors = errors + 1; end
          if (is_full !== e.full) begin
            $error("is_full exp %0d got %0d", e.full, is_full); errors = errors + 1; end
          if (insert_count !== e.c_ins) begin
            $error("insert_count exp %0d got %0d", e.c_ins, insert_count);
            errors = errors + 1; end
          if (fetch_count !== e.c_fetch) begin
            $error("fetch_count exp %0d got %0d", e.c_fetch, fetch_count);
            errors = errors + 1; end
          if (peek_count !== e.c_peek) begin
            $error("peek_count exp %0d got %0d", e.c_peek, peek_count);
            errors = errors + 1; end
          if (flush_count !== e.c_flush) begin
            $error("flush_count exp %0d got %0d", e.c_flush, flush_count);
            errors = errors + 1; end
          if (empty_count !== e.c_empty) begin
            $error("empty_count exp %0d got %0d", e.c_empty, empty_count);
            errors = errors + 1; end
          if (overflow_count !== e.c_ovf) begin
            $error("overflow_count exp %0d got %0d", e.c_ovf, overflow_count);
            errors = errors + 1; end
        end
      end
      if (hold_off) out_ready <= 0;
      else if (out_gap > 0) begin
        out_gap <= out_gap - 1; out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (!quiet && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk) if (cycles >= LIMIT) begin
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, int unsigned val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == mqrm_pkg::REG_CAP) cap_reg = val & 9'h1FF;
    else count_reg = val & 5'h1F;
    reset_queues();
    repeat (NQ + 4) @(posedge clk);
  endtask

  function automatic void push(logic [3:0] c, logic [7:0] q, logic [31:0] it,
                               logic [11:0] s);
    pending_cmds.push_back(cmd_t'{c, q, it, s});
  endfunction

  // random phase: mostly adds and fetches on valid queues, some noise
  task automatic random_phase(int n);
    int unsigned k, q;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      q = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                      : $urandom_range(0, eff_count() > 0 ? eff_count() : 0);
      if (k < 40) push(mqrm_pkg::CMD_ADD, 8'(q), $urandom, 12'($urandom));
      else if (k < 65) push(mqrm_pkg::CMD_FETCH, 8'(q), $urandom, 12'($urandom));
      else if (k < 75) push(mqrm_pkg::CMD_PEEK, 8'(q), $urandom, 12'($urandom));
      else if (k < 85)
        push(mqrm_pkg::CMD_REPLACE, 8'(q), $urandom, 12'($urandom_range(0, 4095)));
      else push(4'($urandom_range(0, 15)), 8'(q), $urandom, 12'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin ring_mem[i] = 0; slot_written[i] = 0; end
    reset_queues();
    repeat (7) @(posedge clk);
    rst <= 0;
    repeat (NQ + 4) @(posedge clk);

    // directed: every command, extremes of fields, invalid ids, empty cases
    push(mqrm_pkg::CMD_FETCH, 0, 0, 0);
    push(mqrm_pkg::CMD_PEEK, 15, 0, 0);
    push(mqrm_pkg::CMD_ADD, 0, 32'hFFFF_FFFF, 12'hFFF);
    push(mqrm_pkg::CMD_ADD, 15, 32'h0, 0);
    push(mqrm_pkg::CMD_PEEK, 0, 0, 0);
    push(mqrm_pkg::CMD_FETCH, 0, 0, 0);
    push(mqrm_pkg::CMD_ADD, 16, 32'h5555_AAAA, 0);
    push(mqrm_pkg::CMD_ADD, 255, 32'hAAAA_5555, 0);
    push(mqrm_pkg::CMD_OVF, 3, 0, 0);
    push(mqrm_pkg::CMD_QUERY, 3, 0, 0);
    push(mqrm_pkg::CMD_REPLACE, 200, 32'h1234_5678, 12'hFFF);
    push(mqrm_pkg::CMD_REPLACE, 1, 32'hDEAD_BEEF, 0);
    push(mqrm_pkg::CMD_FLUSH, 15, 0, 0);
    push(mqrm_pkg::CMD_CLR, 3, 0, 0);
    push(mqrm_pkg::CMD_FLUSH_ALL, 2, 0, 0);
    push(mqrm_pkg::CMD_CLR_ALL, 99, 0, 0);
    push(4'd15, 1, 0, 0);
    push(4'd10, 40, 0, 0);
    wait_drained();

    // capacity 1: full on the second add
    write_reg(mqrm_pkg::REG_CAP, 1);
    push(mqrm_pkg::CMD_ADD, 2, 32'h1, 0);
    push(mqrm_pkg::CMD_ADD, 2, 32'h2, 0);
    push(mqrm_pkg::CMD_PEEK, 2, 0, 0);
    push(mqrm_pkg::CMD_FETCH, 2, 0, 0);
    random_phase(60);
    wait_drained();

    // capacity 0 clamps to 1; no queues at all
    write_reg(mqrm_pkg::REG_CAP, 0);
    write_reg(mqrm_pkg::REG_COUNT, 0);
    random_phase(20);
    wait_drained();

    // small capacity, wrap-around; receiver stalls long to back up the input
    write_reg(mqrm_pkg::REG_COUNT, 3);
    write_reg(mqrm_pkg::REG_CAP, 5);
    hold_off = 1;
    random_phase(150);
    repeat (300) @(posedge clk);
    hold_off = 0;
    wait_drained();

    // oversize values clamp: capacity 511 -> 256, count 31 -> 16
    write_reg(mqrm_pkg::REG_CAP, 511);
    write_reg(mqrm_pkg::REG_COUNT, 31);
    random_phase(100);
    wait_drained();

    write_reg(mqrm_pkg::REG_CAP, 256);
    write_reg(mqrm_pkg::REG_COUNT, 16);
    quiet = 1;
    random_phase(70);
    wait_drained();

    $display("Covered %0d commands over capacities 0..511 and queue counts 0..31,", n_results);
    $display("including empty, full, invalid-id, wrap-around and backpressure cases.");
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
